// ----- design/jddm_pkg.sv -----
package jddm_pkg;

    // Field widths
    localparam int unsigned LO_W    = 4;
    localparam int unsigned HI_W    = 6;
    localparam int unsigned AXIS_W  = 9;   // signed axis value, -255..255
    localparam int unsigned DUTY_W  = 8;
    localparam int unsigned DZ_W    = 8;
    localparam int unsigned TRIG_W  = 17;  // Q1.15 with room for +-1.0
    localparam int unsigned CROSS_W = 27;

    localparam logic [DZ_W-1:0] DEADZONE_RESET = 8'd60;

    // Threshold angle indexes
    localparam int unsigned NUM_ANG = 17;
    localparam int unsigned A_P070 = 0;
    localparam int unsigned A_P087 = 1;
    localparam int unsigned A_P223 = 2;
    localparam int unsigned A_P247 = 3;
    localparam int unsigned A_M240 = 4;
    localparam int unsigned A_M230 = 5;
    localparam int unsigned A_M090 = 6;
    localparam int unsigned A_M060 = 7;
    localparam int unsigned A_ZERO = 8;
    localparam int unsigned A_P079 = 9;
    localparam int unsigned A_P157 = 10;
    localparam int unsigned A_P236 = 11;
    localparam int unsigned A_P314 = 12;
    localparam int unsigned A_M314 = 13;
    localparam int unsigned A_M236 = 14;
    localparam int unsigned A_M157 = 15;
    localparam int unsigned A_M079 = 16;

    // sin(a) and cos(a) of each threshold, scaled by 32768
    localparam logic signed [TRIG_W-1:0] ANG_SIN [NUM_ANG] = '{
        17'sd21110,  17'sd25046,  17'sd25902,  17'sd20389,
        -17'sd22134, -17'sd24435, -17'sd25668, -17'sd18502,
        17'sd0,      17'sd23277,  17'sd32768,  17'sd23082,
        17'sd52,     -17'sd52,    -17'sd23082, -17'sd32768,
        -17'sd23277
    };

    localparam logic signed [TRIG_W-1:0] ANG_COS [NUM_ANG] = '{
        17'sd25062,  17'sd21130,  -17'sd20070, -17'sd25652,
        -17'sd24163, -17'sd21833, 17'sd20369,  17'sd27045,
        17'sd32768,  17'sd23064,  17'sd26,     -17'sd23258,
        -17'sd32768, -17'sd32768, -17'sd23258, 17'sd26,
        17'sd23064
    };

    // Sector decision carried from the cross-product stage to the drive stage
    typedef struct packed {
        logic [NUM_ANG-1:0] pos;      // cross product above zero
        logic [NUM_ANG-1:0] neg;      // cross product below zero
        logic [DUTY_W-1:0]  ax;
        logic [DUTY_W-1:0]  ay;
        logic [DUTY_W-1:0]  remap;    // ||X| - |Y||
        logic               in_dz;    // both axes inside the deadzone
    } sector_t;

endpackage

// ----- design/jddm_axis_store.sv -----
module jddm_axis_store
    import jddm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [LO_W-1:0]          first_byte,
    input  logic [HI_W-1:0]          second_byte,
    output logic                     axis_valid,
    input  logic                     axis_ready,
    output logic signed [AXIS_W-1:0] x,
    output logic signed [AXIS_W-1:0] y
);

    logic                     valid_reg;
    logic signed [AXIS_W-1:0] last_x_reg;
    logic signed [AXIS_W-1:0] last_y_reg;
    logic [LO_W+HI_W-1:0]     z;
    logic signed [11:0]       span;
    logic signed [AXIS_W-1:0] v;
    logic                     accept;

    // 2z - 1023, then divide by 4 toward zero; span is always odd
    always_comb
    begin
        z    = {second_byte, first_byte};
        span = $signed({1'b0, z, 1'b0}) - 12'sd1023;
        v    = AXIS_W'(span >>> 2) + AXIS_W'(span[11]);
    end

    assign in_ready   = !valid_reg || axis_ready;
    assign accept     = in_valid && in_ready;
    assign axis_valid = valid_reg;
    assign x          = last_x_reg;
    assign y          = last_y_reg;

    // Last X and Y; the pair doubles as this stage's payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            last_x_reg <= '0;
            last_y_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                valid_reg <= 1'b1;
                if (first_byte[0])
                    last_x_reg <= v;
                else
                    last_y_reg <= v;
            end
            else if (axis_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- design/jddm_sector.sv -----
module jddm_sector
    import jddm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [DZ_W-1:0]          deadzone,
    input  logic                     axis_valid,
    output logic                     axis_ready,
    input  logic signed [AXIS_W-1:0] x,
    input  logic signed [AXIS_W-1:0] y,
    output logic                     sec_valid,
    input  logic                     sec_ready,
    output sector_t                  sec
);

    logic                      valid_reg;
    sector_t                   sec_reg;
    sector_t                   sec_next;
    logic signed [CROSS_W-1:0] cross_val [NUM_ANG];
    logic [AXIS_W-1:0]         abs_x;
    logic [AXIS_W-1:0]         abs_y;
    logic [DUTY_W:0]           diff;

    // Y*cos(a) - X*sin(a) for each threshold, kept as sign flags;
    // magnitudes and deadzone test
    always_comb
    begin
        for (int i = 0; i < NUM_ANG; i++)
        begin
            cross_val[i] = CROSS_W'(y) * CROSS_W'(ANG_COS[i])
                         - CROSS_W'(x) * CROSS_W'(ANG_SIN[i]);
            sec_next.neg[i] = cross_val[i][CROSS_W-1];
            sec_next.pos[i] = !cross_val[i][CROSS_W-1] && (cross_val[i] != '0);
        end

        abs_x          = x[AXIS_W-1] ? AXIS_W'(-x) : AXIS_W'(x);
        abs_y          = y[AXIS_W-1] ? AXIS_W'(-y) : AXIS_W'(y);
        sec_next.ax    = abs_x[DUTY_W-1:0];
        sec_next.ay    = abs_y[DUTY_W-1:0];
        diff           = {1'b0, sec_next.ax} - {1'b0, sec_next.ay};
        sec_next.remap = diff[DUTY_W] ? DUTY_W'(-diff) : diff[DUTY_W-1:0];
        sec_next.in_dz = (sec_next.ax < deadzone) && (sec_next.ay < deadzone);
    end

    assign axis_ready = !valid_reg || sec_ready;
    assign sec_valid  = valid_reg;
    assign sec        = sec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (axis_ready)
        begin
            valid_reg <= axis_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (axis_valid && axis_ready)
            sec_reg <= sec_next;
    end

endmodule

// ----- design/jddm_drive_select.sv -----
module jddm_drive_select
    import jddm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sec_valid,
    output logic              sec_ready,
    input  sector_t           sec,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DUTY_W-1:0] left_duty,
    output logic [DUTY_W-1:0] right_duty,
    output logic              left_forward,
    output logic              right_forward
);

    logic              out_valid_reg;
    logic [DUTY_W-1:0] left_duty_reg;
    logic [DUTY_W-1:0] right_duty_reg;
    logic              left_dir_reg;
    logic              right_dir_reg;
    logic [DUTY_W-1:0] left_duty_next;
    logic [DUTY_W-1:0] right_duty_next;
    logic              left_dir_next;
    logic              right_dir_next;

    // Band priority; anything not matched keeps its held value
    always_comb
    begin
        left_duty_next  = left_duty_reg;
        right_duty_next = right_duty_reg;
        left_dir_next   = left_dir_reg;
        right_dir_next  = right_dir_reg;
        if (sec.in_dz)
        begin
            left_duty_next  = '0;
            right_duty_next = '0;
            left_dir_next   = 1'b0;
            right_dir_next  = 1'b0;
        end
        else if (sec.pos[A_P070] && sec.neg[A_P087])
        begin
            right_duty_next = '0;
            right_dir_next  = 1'b0;
            left_duty_next  = sec.ax;
        end
        else if (sec.pos[A_P223] && sec.neg[A_P247])
        begin
            left_duty_next  = '0;
            left_dir_next   = 1'b0;
            right_duty_next = sec.ax;
        end
        else if (sec.pos[A_M240] && sec.neg[A_M230])
        begin
            right_duty_next = '0;
            left_dir_next   = 1'b0;
            left_duty_next  = sec.ax;
        end
        else if (sec.pos[A_M090] && sec.neg[A_M060])
        begin
            left_duty_next  = '0;
            right_dir_next  = 1'b0;
            right_duty_next = sec.ax;
        end
        else if (sec.pos[A_ZERO] && sec.neg[A_P079])
        begin
            left_duty_next  = sec.ax;
            left_dir_next   = 1'b1;
            right_duty_next = sec.remap;
            right_dir_next  = 1'b0;
        end
        else if (sec.pos[A_P079] && sec.neg[A_P157])
        begin
            left_duty_next  = sec.ay;
            left_dir_next   = 1'b1;
            right_duty_next = sec.remap;
            right_dir_next  = 1'b1;
        end
        else if (sec.pos[A_P157] && sec.neg[A_P236])
        begin
            left_duty_next  = sec.remap;
            left_dir_next   = 1'b1;
            right_duty_next = sec.ay;
            right_dir_next  = 1'b1;
        end
        else if (sec.pos[A_P236] && sec.neg[A_P314])
        begin
            left_duty_next  = sec.remap;
            left_dir_next   = 1'b0;
            right_duty_next = sec.ax;
            right_dir_next  = 1'b1;
        end
        else if (sec.pos[A_M314] && !sec.pos[A_M236])
        begin
            // upper edge of this band is inclusive
            left_duty_next  = sec.ax;
            left_dir_next   = 1'b0;
            right_duty_next = sec.remap;
            right_dir_next  = 1'b1;
        end
        else if (sec.pos[A_M236] && sec.neg[A_M157])
        begin
            left_duty_next  = sec.ay;
            left_dir_next   = 1'b0;
            right_duty_next = sec.remap;
            right_dir_next  = 1'b0;
        end
        else if (sec.pos[A_M157] && sec.neg[A_M079])
        begin
            left_duty_next  = sec.remap;
            left_dir_next   = 1'b0;
            right_duty_next = sec.ay;
            right_dir_next  = 1'b0;
        end
        else if (sec.pos[A_M079] && sec.neg[A_ZERO])
        begin
            left_duty_next  = sec.remap;
            left_dir_next   = 1'b1;
            right_duty_next = sec.ax;
            right_dir_next  = 1'b0;
        end
    end

    assign sec_ready     = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign left_duty     = left_duty_reg;
    assign right_duty    = right_duty_reg;
    assign left_forward  = left_dir_reg;
    assign right_forward = right_dir_reg;

    // Held drive values are also the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            left_duty_reg  <= '0;
            right_duty_reg <= '0;
            left_dir_reg   <= 1'b0;
            right_dir_reg  <= 1'b0;
        end
        else
        begin
            if (sec_valid && sec_ready)
            begin
                out_valid_reg  <= 1'b1;
                left_duty_reg  <= left_duty_next;
                right_duty_reg <= right_duty_next;
                left_dir_reg   <= left_dir_next;
                right_dir_reg  <= right_dir_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- design/joystick_differential_drive_mixer.sv -----
// Channel   Handshake              Payload
// in        in_valid / in_ready    first_byte[3:0], second_byte[5:0]
// cfg       cfg_valid / cfg_ready  cfg_data[7:0] (deadzone)
// out       out_valid / out_ready  left_duty, right_duty, left_forward, right_forward
//
// One request per cycle while out_ready is high; each taken request passes through
// the axis store, cross-product stage and drive select registers in that order.
// Reset clears the stored axes and held drive values to zero, deadzone to 60.
// Stalls on out_ready back up stage by stage; each stage still fills while the
// one after it holds a result. cfg_ready is always high.
module joystick_differential_drive_mixer
    import jddm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [LO_W-1:0]   first_byte,
    input  logic [HI_W-1:0]   second_byte,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [DZ_W-1:0]   cfg_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DUTY_W-1:0] left_duty,
    output logic [DUTY_W-1:0] right_duty,
    output logic              left_forward,
    output logic              right_forward
);

    logic [DZ_W-1:0]          deadzone_reg;
    logic                     axis_valid;
    logic                     axis_ready;
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic                     sec_valid;
    logic                     sec_ready;
    sector_t                  sec;

    // Deadzone register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            deadzone_reg <= DEADZONE_RESET;
        else if (cfg_valid && cfg_ready)
            deadzone_reg <= cfg_data;
    end

    jddm_axis_store u_axis_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .axis_valid  (axis_valid),
        .axis_ready  (axis_ready),
        .x           (x),
        .y           (y)
    );

    jddm_sector u_sector (
        .clk        (clk),
        .rst_n      (rst_n),
        .deadzone   (deadzone_reg),
        .axis_valid (axis_valid),
        .axis_ready (axis_ready),
        .x          (x),
        .y          (y),
        .sec_valid  (sec_valid),
        .sec_ready  (sec_ready),
        .sec        (sec)
    );

    jddm_drive_select u_drive_select (
        .clk           (clk),
        .rst_n         (rst_n),
        .sec_valid     (sec_valid),
        .sec_ready     (sec_ready),
        .sec           (sec),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .left_duty     (left_duty),
        .right_duty    (right_duty),
        .left_forward  (left_forward),
        .right_forward (right_forward)
    );

endmodule
